/* rtl/ttmm_pkg.sv */
// ttmm_pkg: shared types, constants and codes of the touch trimmed-mean mapper
package ttmm_pkg;

   localparam int SAMPLE_COUNT_DEF = 15;
   localparam int TRIM_COUNT_DEF   = 5;
   localparam int SAMPLE_BITS      = 12;
   localparam int COORD_BITS       = 9;
   localparam int GAIN_BITS        = 16;
   localparam int ROT_BITS         = 2;
   localparam int SCREEN_WIDTH     = 240;
   localparam int SCREEN_HEIGHT    = 320;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROTATION = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_OFFSET = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_OFFSET = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_GAIN   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_GAIN   = 3'd4;

   localparam logic [ROT_BITS-1:0] ROT_0   = 2'd0;
   localparam logic [ROT_BITS-1:0] ROT_90  = 2'd1;
   localparam logic [ROT_BITS-1:0] ROT_180 = 2'd2;
   localparam logic [ROT_BITS-1:0] ROT_270 = 2'd3;

   localparam logic [ROT_BITS-1:0]    ROTATION_RESET = 2'd0;
   localparam logic [SAMPLE_BITS-1:0] X_OFFSET_RESET = 12'd90;
   localparam logic [SAMPLE_BITS-1:0] Y_OFFSET_RESET = 12'd90;
   localparam logic [GAIN_BITS-1:0]   X_GAIN_RESET   = 16'd1702;
   localparam logic [GAIN_BITS-1:0]   Y_GAIN_RESET   = 16'd2300;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] x_sample;
      logic [SAMPLE_BITS-1:0] y_sample;
      logic                   pen_down;
   } req_type;

   typedef struct packed {
      logic                  touched;
      logic [COORD_BITS-1:0] x_coord;
      logic [COORD_BITS-1:0] y_coord;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_SUB,
      ST_MUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic insert;
      logic clear;
      logic acc_init;
      logic acc_step;
      logic sub;
      logic mul;
      logic emit_point;
      logic emit_abort;
   } cmd_type;

   typedef struct packed {
      logic set_full;
      logic acc_last;
   } status_type;

endpackage

/* rtl/touch_trimmed_mean_mapper_top.sv */
// touch_trimmed_mean_mapper_top: top level of the resistive touch trimmed-mean mapper
//
// A sample pair is taken when start is high and busy is low. A pen-down pair
// is inserted into two sorted rows and gives no result until SAMPLE_COUNT
// pairs are held; the pair that completes the set raises busy while the
// trimmed sum walks the KEPT = SAMPLE_COUNT - 2*TRIM_COUNT kept middle entries
// one per cycle, then offset removal, the gain multiply and clamp with rotation
// follow in turn. A pen-up pair aborts the set without raising busy. Every
// result appears with rsp_valid for exactly one cycle, in the cycle after
// ST_OUT or after the pen-up pair is taken; the receiver cannot stall it.
// Configuration transfers are always ready.
module touch_trimmed_mean_mapper_top #(
   parameter int SAMPLE_COUNT = ttmm_pkg::SAMPLE_COUNT_DEF,
   parameter int TRIM_COUNT   = ttmm_pkg::TRIM_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  ttmm_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output ttmm_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ttmm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ttmm_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int KEPT = (SAMPLE_COUNT > 2 * TRIM_COUNT) ? SAMPLE_COUNT - 2 * TRIM_COUNT : 0;

   ttmm_pkg::cmd_type    cmd;
   ttmm_pkg::status_type status;

   assign csr_ready = 1'b1;

   ttmm_ctrl #(
      .KEPT (KEPT)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .pen_down (req_data.pen_down),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   ttmm_datapath #(
      .SAMPLE_COUNT (SAMPLE_COUNT),
      .TRIM_COUNT   (TRIM_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/ttmm_ctrl.sv */
// ttmm_ctrl: sequencer for sample insertion, trimmed sum, scaling and result transfer
module ttmm_ctrl #(
   parameter int KEPT = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                pen_down,
   input  ttmm_pkg::status_type status,
   output ttmm_pkg::cmd_type   cmd,
   output logic                busy
);

   ttmm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttmm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ttmm_pkg::ST_IDLE: begin
            if (start) begin
               if (pen_down) begin
                  cmd.insert = 1'b1;
                  if (status.set_full) begin
                     cmd.acc_init = 1'b1;
                     state_in = (KEPT == 0) ? ttmm_pkg::ST_SUB : ttmm_pkg::ST_ACC;
                  end
               end else begin
                  cmd.clear      = 1'b1;
                  cmd.emit_abort = 1'b1;
               end
            end
         end
         ttmm_pkg::ST_ACC: begin
            cmd.acc_step = 1'b1;
            if (status.acc_last) begin
               state_in = ttmm_pkg::ST_SUB;
            end
         end
         ttmm_pkg::ST_SUB: begin
            cmd.sub  = 1'b1;
            state_in = ttmm_pkg::ST_MUL;
         end
         ttmm_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ttmm_pkg::ST_OUT;
         end
         ttmm_pkg::ST_OUT: begin
            cmd.emit_point = 1'b1;
            state_in       = ttmm_pkg::ST_IDLE;
         end
         default: begin
            state_in = ttmm_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ttmm_pkg::ST_IDLE);

endmodule

/* rtl/ttmm_datapath.sv */
// ttmm_datapath: sorted sample rows, trimmed sums, offset and gain scaling, clamp, rotation
module ttmm_datapath #(
   parameter int SAMPLE_COUNT = ttmm_pkg::SAMPLE_COUNT_DEF,
   parameter int TRIM_COUNT   = ttmm_pkg::TRIM_COUNT_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ttmm_pkg::req_type                      req_data,
   input  ttmm_pkg::cmd_type                      cmd,
   output ttmm_pkg::status_type                   status,
   input  logic                                   csr_write,
   input  logic [ttmm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ttmm_pkg::CSR_DATA_BITS-1:0]     csr_data,
   output logic                                   rsp_valid,
   output ttmm_pkg::rsp_type                      rsp_data
);

   localparam int SB     = ttmm_pkg::SAMPLE_BITS;
   localparam int GB     = ttmm_pkg::GAIN_BITS;
   localparam int CB     = ttmm_pkg::COORD_BITS;
   localparam int KEPT   = (SAMPLE_COUNT > 2 * TRIM_COUNT) ? SAMPLE_COUNT - 2 * TRIM_COUNT : 0;
   localparam int CNT_W  = $clog2(SAMPLE_COUNT + 1);
   localparam int IDX_W  = $clog2(SAMPLE_COUNT);
   localparam int SUM_W  = SB + CNT_W;
   localparam int PROD_W = SUM_W + GB;

   logic [ttmm_pkg::ROT_BITS-1:0] rotation_ff;
   logic [SB-1:0]                 x_offset_ff, y_offset_ff;
   logic [GB-1:0]                 x_gain_ff, y_gain_ff;

   logic [SB-1:0] xs_ff [SAMPLE_COUNT];
   logic [SB-1:0] ys_ff [SAMPLE_COUNT];
   logic [SB-1:0] xs_in [SAMPLE_COUNT];
   logic [SB-1:0] ys_in [SAMPLE_COUNT];
   logic [SAMPLE_COUNT-1:0] x_le, y_le;

   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [CNT_W-1:0]  remain_ff;
   logic [SUM_W-1:0]  x_sum_ff, y_sum_ff;
   logic [SUM_W-1:0]  x_diff_ff, y_diff_ff;
   logic [PROD_W-1:0] x_prod_ff, y_prod_ff;
   logic [SUM_W-1:0]  x_sub, y_sub;
   logic [SUM_W-1:0]  x_scaled, y_scaled;
   logic [CB-1:0]     rx, ry, rx_inv, ry_inv, ox, oy;

   logic              rsp_valid_ff;
   ttmm_pkg::rsp_type rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff <= ttmm_pkg::ROTATION_RESET;
         x_offset_ff <= ttmm_pkg::X_OFFSET_RESET;
         y_offset_ff <= ttmm_pkg::Y_OFFSET_RESET;
         x_gain_ff   <= ttmm_pkg::X_GAIN_RESET;
         y_gain_ff   <= ttmm_pkg::Y_GAIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            ttmm_pkg::CSR_ROTATION: rotation_ff <= csr_data[ttmm_pkg::ROT_BITS-1:0];
            ttmm_pkg::CSR_X_OFFSET: x_offset_ff <= csr_data[SB-1:0];
            ttmm_pkg::CSR_Y_OFFSET: y_offset_ff <= csr_data[SB-1:0];
            ttmm_pkg::CSR_X_GAIN:   x_gain_ff   <= csr_data[GB-1:0];
            ttmm_pkg::CSR_Y_GAIN:   y_gain_ff   <= csr_data[GB-1:0];
            default: begin
            end
         endcase
      end
   end

   // insertion into the sorted rows
   always_comb begin
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         x_le[i] = (CNT_W'(i) < count_ff) && (xs_ff[i] <= req_data.x_sample);
         y_le[i] = (CNT_W'(i) < count_ff) && (ys_ff[i] <= req_data.y_sample);
      end
      xs_in[0] = x_le[0] ? xs_ff[0] : req_data.x_sample;
      ys_in[0] = y_le[0] ? ys_ff[0] : req_data.y_sample;
      for (int i = 1; i < SAMPLE_COUNT; i++) begin
         xs_in[i] = x_le[i] ? xs_ff[i] : (x_le[i-1] ? req_data.x_sample : xs_ff[i-1]);
         ys_in[i] = y_le[i] ? ys_ff[i] : (y_le[i-1] ? req_data.y_sample : ys_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         for (int i = 0; i < SAMPLE_COUNT; i++) begin
            xs_ff[i] <= xs_in[i];
            ys_ff[i] <= ys_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (cmd.insert) begin
         count_ff <= status.set_full ? '0 : count_ff + CNT_W'(1);
      end
   end

   assign status.set_full = (count_ff == CNT_W'(SAMPLE_COUNT - 1));
   assign status.acc_last = (remain_ff == CNT_W'(1));

   // trimmed sum, one kept entry per cycle
   always_ff @(posedge clock) begin
      if (cmd.acc_init) begin
         x_sum_ff  <= '0;
         y_sum_ff  <= '0;
         rd_idx_ff <= IDX_W'(TRIM_COUNT);
         remain_ff <= CNT_W'(KEPT);
      end else if (cmd.acc_step) begin
         x_sum_ff  <= x_sum_ff + SUM_W'(xs_ff[rd_idx_ff]);
         y_sum_ff  <= y_sum_ff + SUM_W'(ys_ff[rd_idx_ff]);
         rd_idx_ff <= rd_idx_ff + IDX_W'(1);
         remain_ff <= remain_ff - CNT_W'(1);
      end
   end

   // offset removal and gain
   assign x_sub = SUM_W'(KEPT) * SUM_W'(x_offset_ff);
   assign y_sub = SUM_W'(KEPT) * SUM_W'(y_offset_ff);

   always_ff @(posedge clock) begin
      if (cmd.sub) begin
         x_diff_ff <= (x_sum_ff > x_sub) ? x_sum_ff - x_sub : '0;
         y_diff_ff <= (y_sum_ff > y_sub) ? y_sum_ff - y_sub : '0;
      end
      if (cmd.mul) begin
         x_prod_ff <= PROD_W'(x_diff_ff) * PROD_W'(x_gain_ff);
         y_prod_ff <= PROD_W'(y_diff_ff) * PROD_W'(y_gain_ff);
      end
   end

   // clamp and rotation
   always_comb begin
      x_scaled = x_prod_ff[PROD_W-1:GB];
      y_scaled = y_prod_ff[PROD_W-1:GB];
      rx = (x_scaled >= SUM_W'(ttmm_pkg::SCREEN_WIDTH - 1)) ?
           CB'(ttmm_pkg::SCREEN_WIDTH - 1) : x_scaled[CB-1:0];
      ry = (y_scaled >= SUM_W'(ttmm_pkg::SCREEN_HEIGHT)) ?
           CB'(ttmm_pkg::SCREEN_HEIGHT) : y_scaled[CB-1:0];
      rx_inv = CB'(ttmm_pkg::SCREEN_WIDTH - 1) - rx;
      ry_inv = (ry == CB'(ttmm_pkg::SCREEN_HEIGHT)) ?
               CB'(ttmm_pkg::SCREEN_HEIGHT) : CB'(ttmm_pkg::SCREEN_HEIGHT - 1) - ry;
      case (rotation_ff)
         ttmm_pkg::ROT_0: begin
            ox = rx;
            oy = ry;
         end
         ttmm_pkg::ROT_90: begin
            ox = ry_inv;
            oy = rx;
         end
         ttmm_pkg::ROT_180: begin
            ox = rx_inv;
            oy = ry_inv;
         end
         default: begin
            ox = ry;
            oy = rx_inv;
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_point | cmd.emit_abort;
      end
      if (cmd.emit_point) begin
         rsp_ff.touched <= 1'b1;
         rsp_ff.x_coord <= ox;
         rsp_ff.y_coord <= oy;
      end else if (cmd.emit_abort) begin
         rsp_ff <= '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
